### src/alab_pkg.sv
// Shared constants and types for the ambient-light auto-brightness block.
package alab_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int LEVEL_BITS      = 8;

    localparam logic [LEVEL_BITS-1:0] CAP_RESET   = 8'd255;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 8'd255;

    // Calibration window constants, in sensor counts.
    localparam int HALF_SPAN = 48;
    localparam int MIN_SPAN  = 96;
    localparam int DARK_BAND = 10;

    // Level constants, in brightness steps.
    localparam logic [LEVEL_BITS-1:0] FLOOR_LEVEL = 8'd4;
    localparam logic [LEVEL_BITS-1:0] TARGET_BAND = 8'd5;
    localparam logic [LEVEL_BITS-1:0] HOLD_BAND   = 8'd2;
    localparam logic [LEVEL_BITS-1:0] FLOOR_STEP  = 8'd2;

    // Command from the sequencer to the target and slew stage.
    typedef struct packed {
        logic                  commit;
        logic                  restart;
        logic [LEVEL_BITS-1:0] meas;
        logic [LEVEL_BITS-1:0] cap;
    } slew_cmd_t;

endpackage

### src/alab_div.sv
// Restoring divider that produces one quotient bit per cycle.
module alab_div
    import alab_pkg::*;
#(
    parameter int DW = SAMPLE_BITS_DEF + LEVEL_BITS,
    parameter int VW = SAMPLE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW:0]   shifted;
    logic          ge;

    assign shifted = {rem_reg, dvd_reg[DW-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // The dividend register shifts left and collects quotient bits.
            rem_next = ge ? VW'(shifted - {1'b0, dsr_reg}) : shifted[VW-1:0];
            dvd_next = {dvd_reg[DW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

### src/alab_slew.sv
// Target hysteresis and slew-limited backlight level registers.
module alab_slew
    import alab_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  slew_cmd_t             cmd,
    output logic [LEVEL_BITS-1:0] level,
    output logic                  written
);

    logic [LEVEL_BITS-1:0] target_reg, target_next;
    logic                  tready_reg;
    logic [LEVEL_BITS-1:0] cur_reg, cur_next;
    logic                  applied_reg;
    logic                  written_reg, written_next;

    logic                  tready_eff;
    logic [LEVEL_BITS-1:0] tdiff;
    logic [LEVEL_BITS-1:0] step_base;
    logic [LEVEL_BITS-1:0] step;
    logic [LEVEL_BITS-1:0] gap;

    always_comb
    begin
        tready_eff  = tready_reg && !cmd.restart;
        tdiff       = (cmd.meas > target_reg) ? cmd.meas - target_reg
                                              : target_reg - cmd.meas;
        target_next = (!tready_eff || tdiff > TARGET_BAND) ? cmd.meas : target_reg;

        step_base = (cmd.cap >> 5) < FLOOR_STEP ? FLOOR_STEP : (cmd.cap >> 5);
        gap       = (cur_reg > target_next) ? cur_reg - target_next
                                            : target_next - cur_reg;
        step      = (gap < step_base) ? gap : step_base;

        if (!applied_reg)
        begin
            cur_next = target_next;
        end
        else if (gap <= HOLD_BAND)
        begin
            cur_next = cur_reg;
        end
        else if (target_next > cur_reg)
        begin
            cur_next = cur_reg + step;
        end
        else
        begin
            cur_next = cur_reg - step;
        end
        written_next = !applied_reg || (cur_next != cur_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= LEVEL_RESET;
            tready_reg  <= 1'b0;
            cur_reg     <= LEVEL_RESET;
            applied_reg <= 1'b0;
            written_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            target_reg  <= target_next;
            tready_reg  <= 1'b1;
            written_reg <= written_next;
            if (written_next)
            begin
                cur_reg     <= cur_next;
                applied_reg <= 1'b1;
            end
        end
    end

    assign level   = cur_reg;
    assign written = written_reg;

endmodule

### src/ambient_light_auto_brightness_top.sv
// Top level of the ambient-light auto-brightness controller.
//
// Each input beat carries one raw light reading (bright reads low) and a
// restart flag, and produces exactly one output beat with the backlight level
// and a flag telling whether the level was driven. The reading is smoothed,
// tracked against a min/max calibration window, mapped onto the range between
// a floor level and the brightness cap, filtered by a target hysteresis and
// then slewed. A zero cap skips the calibration and the divider; otherwise
// most of the work on a sample is done by the restoring divider, which
// resolves one quotient bit per cycle over the SAMPLE_BITS + 8 bit product
// of range and ambient light. The input is not ready while a sample is in
// work; an output register holds the finished beat, so the next sample can
// be taken while the previous result still waits for the consumer. The cap
// register is written through its own channel, which is always ready; write
// it only while no sample is in work.
module ambient_light_auto_brightness_top
    import alab_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] light_sample,
    input  logic                   restart,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [LEVEL_BITS-1:0]  level,
    output logic                   written,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LEVEL_BITS-1:0]  max_brightness
);

    localparam int SW = SAMPLE_BITS;
    localparam int PW = SAMPLE_BITS + LEVEL_BITS;

    localparam logic [SW-1:0] SAMPLE_MAX = '1;

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SMOOTH   = 4'd1;
    localparam logic [3:0] S_WINDOW   = 4'd2;
    localparam logic [3:0] S_PREP     = 4'd3;
    localparam logic [3:0] S_MUL      = 4'd4;
    localparam logic [3:0] S_DIV_GO   = 4'd5;
    localparam logic [3:0] S_DIV_WAIT = 4'd6;
    localparam logic [3:0] S_SLEW     = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [LEVEL_BITS-1:0] cap_reg;
    logic [SW-1:0]         raw_reg, raw_next;
    logic                  restart_reg, restart_next;
    logic [SW-1:0]         smooth_reg, smooth_next;
    logic [SW-1:0]         wlow_reg, wlow_next;
    logic [SW-1:0]         whigh_reg, whigh_next;
    logic                  wready_reg, wready_next;
    logic [SW-1:0]         ambient_reg, ambient_next;
    logic [SW-1:0]         span_reg, span_next;
    logic [LEVEL_BITS-1:0] floor_reg, floor_next;
    logic [LEVEL_BITS-1:0] range_reg, range_next;
    logic [PW-1:0]         product_reg, product_next;
    logic [LEVEL_BITS-1:0] meas_reg, meas_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic                  written_reg, written_next;

    logic                  div_start;
    logic                  div_done;
    logic [PW-1:0]         div_q;
    slew_cmd_t             slew_cmd;
    logic [LEVEL_BITS-1:0] slew_level;
    logic                  slew_written;

    logic [SW+1:0]         smooth_sum;
    logic [SW-1:0]         low_mm;
    logic [SW-1:0]         high_mm;
    logic [SW-1:0]         smooth_c;
    logic [SW-1:0]         raw_c;
    logic [LEVEL_BITS-1:0] floor_raw;
    logic                  out_free;

    // Lower edge of a window seeded around a centre value.
    function automatic logic [SW-1:0] seed_low(input logic [SW-1:0] c);
        return (c > SW'(HALF_SPAN)) ? c - SW'(HALF_SPAN) : '0;
    endfunction

    // Upper edge of a seeded window, saturated to the largest reading.
    function automatic logic [SW-1:0] seed_high(input logic [SW-1:0] c);
        logic [SW:0] sum;
        sum = {1'b0, c} + (SW + 1)'(HALF_SPAN);
        return (sum > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : sum[SW-1:0];
    endfunction

    assign smooth_sum = {1'b0, smooth_reg, 1'b0} + {2'b00, smooth_reg} + {2'b00, raw_reg};
    assign low_mm     = (smooth_reg < wlow_reg) ? smooth_reg : wlow_reg;
    assign high_mm    = (smooth_reg > whigh_reg) ? smooth_reg : whigh_reg;
    assign smooth_c   = (smooth_reg < wlow_reg) ? wlow_reg :
                        (smooth_reg > whigh_reg) ? whigh_reg : smooth_reg;
    assign raw_c      = (raw_reg < wlow_reg) ? wlow_reg :
                        (raw_reg > whigh_reg) ? whigh_reg : raw_reg;
    assign floor_raw  = ((cap_reg >> 4) < FLOOR_LEVEL) ? FLOOR_LEVEL : (cap_reg >> 4);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        raw_next       = raw_reg;
        restart_next   = restart_reg;
        smooth_next    = smooth_reg;
        wlow_next      = wlow_reg;
        whigh_next     = whigh_reg;
        wready_next    = wready_reg;
        ambient_next   = ambient_reg;
        span_next      = span_reg;
        floor_next     = floor_reg;
        range_next     = range_reg;
        product_next   = product_reg;
        meas_next      = meas_reg;
        out_valid_next = out_valid_reg && !out_ready;
        level_next     = level_reg;
        written_next   = written_reg;
        div_start      = 1'b0;
        slew_cmd       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    raw_next     = light_sample;
                    restart_next = restart;
                    if (restart)
                    begin
                        wready_next = 1'b0;
                    end
                    state_next = S_SMOOTH;
                end
            end
            S_SMOOTH:
            begin
                if (cap_reg == '0)
                begin
                    // A zero cap measures as zero and leaves calibration alone.
                    meas_next  = '0;
                    state_next = S_SLEW;
                end
                else
                begin
                    if (!wready_reg)
                    begin
                        smooth_next = raw_reg;
                        wlow_next   = seed_low(raw_reg);
                        whigh_next  = seed_high(raw_reg);
                        wready_next = 1'b1;
                    end
                    else
                    begin
                        smooth_next = smooth_sum[SW+1:2];
                    end
                    state_next = S_WINDOW;
                end
            end
            S_WINDOW:
            begin
                // Widen the window to the smoothed value, reseed if too narrow.
                if ((high_mm - low_mm) < SW'(MIN_SPAN))
                begin
                    wlow_next  = seed_low(smooth_reg);
                    whigh_next = seed_high(smooth_reg);
                end
                else
                begin
                    wlow_next  = low_mm;
                    whigh_next = high_mm;
                end
                state_next = S_PREP;
            end
            S_PREP:
            begin
                span_next    = (whigh_reg > wlow_reg) ? whigh_reg - wlow_reg : SW'(1);
                ambient_next = ((whigh_reg - raw_c) <= SW'(DARK_BAND)) ? '0
                                                                       : whigh_reg - smooth_c;
                floor_next   = (floor_raw > cap_reg) ? cap_reg : floor_raw;
                range_next   = cap_reg - ((floor_raw > cap_reg) ? cap_reg : floor_raw);
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                product_next = {{SW{1'b0}}, range_reg} * {{LEVEL_BITS{1'b0}}, ambient_reg};
                state_next   = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    meas_next  = floor_reg + div_q[LEVEL_BITS-1:0];
                    state_next = S_SLEW;
                end
            end
            S_SLEW:
            begin
                slew_cmd.commit  = 1'b1;
                slew_cmd.restart = restart_reg;
                slew_cmd.meas    = meas_reg;
                slew_cmd.cap     = cap_reg;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    level_next     = slew_level;
                    written_next   = slew_written;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            smooth_reg    <= '0;
            wlow_reg      <= '0;
            whigh_reg     <= SAMPLE_MAX;
            wready_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            smooth_reg    <= smooth_next;
            wlow_reg      <= wlow_next;
            whigh_reg     <= whigh_next;
            wready_reg    <= wready_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                cap_reg <= max_brightness;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg     <= raw_next;
        restart_reg <= restart_next;
        ambient_reg <= ambient_next;
        span_reg    <= span_next;
        floor_reg   <= floor_next;
        range_reg   <= range_next;
        product_reg <= product_next;
        meas_reg    <= meas_next;
        level_reg   <= level_next;
        written_reg <= written_next;
    end

    alab_div #(
        .DW (PW),
        .VW (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    alab_slew u_slew (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (slew_cmd),
        .level   (slew_level),
        .written (slew_written)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign written   = written_reg;

    // The calibration window never inverts.
    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        whigh_reg >= wlow_reg)
        else $error("calibration window inverted");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside its wait state");

    // The scaled ambient term never exceeds the level range above the floor.
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> div_q <= PW'(range_reg))
        else $error("scaled ambient term exceeds level range");

endmodule
